// File: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared widths, command codes, status codes and the front/back queue entry
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int Width  = 32;
   localparam int DWidth = 2 * Width;
   localparam int QDepth = 2;

   typedef enum logic [2:0] {
      CMD_NORM = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_LT   = 3'd5,
      CMD_EQ   = 3'd6,
      CMD_NONE = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_WIDE  = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   // classified request: operands in sign/magnitude, early status
   typedef struct packed {
      cmd_type            cmd;
      status_type         st;
      logic               a_neg;
      logic [Width-1:0]   a_n;
      logic [Width-1:0]   a_d;
      logic               b_neg;
      logic [Width-1:0]   b_n;
      logic [Width-1:0]   b_d;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

endpackage

// File: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// zero denominators and the unused command go straight to the output, other
// requests pass through the shared gcd/divide unit (binary gcd, then two
// divisions, up to three passes)
// one request at a time in the back; a two-entry queue buffers new requests
// synchronous active-high reset empties the queue and the result register
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [2:0]       req_command,
   input  logic [Width-1:0] req_a_num,
   input  logic [Width-1:0] req_a_den,
   input  logic [Width-1:0] req_b_num,
   input  logic [Width-1:0] req_b_den,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [Width-1:0] rsp_res_num,
   output logic [Width-2:0] rsp_res_den,
   output logic             rsp_truth,
   output logic [1:0]       rsp_status
);

   entry_type f_entry, q_entry;
   qctl_type  qctl;
   logic      q_full, q_empty, q_pop;

   rau_front u_front (
      .req_command, .req_a_num, .req_a_den, .req_b_num, .req_b_den, .entry(f_entry)
   );

   always_comb begin
      qctl.push  = req_push;
      qctl.pop   = q_pop;
   end

   rau_queue u_queue (
      .clock, .reset, .ctl_i(qctl), .full(q_full), .empty(q_empty),
      .din(f_entry), .dout(q_entry)
   );

   rau_back u_back (
      .clock, .reset, .q_empty, .q_data(q_entry), .q_pop,
      .rsp_empty, .rsp_pop, .rsp_res_num, .rsp_res_den, .rsp_truth, .rsp_status
   );

   assign req_full = q_full;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status != ST_UNUSED)
      else $error("bad status");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> (rsp_res_num == '0 && rsp_res_den == '0 && !rsp_truth))
      else $error("error result not cleared");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_OK && !rsp_truth && rsp_res_num != '0) |-> rsp_res_den != '0)
      else $error("zero denominator on ok result");

endmodule

// File: src/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// reduces a double-width fraction: binary gcd, then two restoring divisions
// ----------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DWidth-1:0] n_in,
   input  logic [DWidth-1:0] d_in,
   output logic              done,
   output logic [DWidth-1:0] n_out,
   output logic [DWidth-1:0] d_out
);

   typedef enum logic [2:0] {
      S_IDLE, S_GCD, S_DIVN, S_DIVD, S_DONE
   } state_type;

   localparam int CntW = $clog2(DWidth + 1);
   localparam int IdxW = $clog2(DWidth);

   state_type         state_ff, state_in;
   logic [DWidth-1:0] x_ff, x_in, y_ff, y_in;
   logic [DWidth-1:0] n_ff, n_in2, d_ff, d_in2;
   logic [CntW-1:0]   k_ff, k_in, cnt_ff, cnt_in;
   logic [DWidth-1:0] g_ff, g_in;
   logic [DWidth-1:0] q_ff, q_in;
   logic [DWidth:0]   rem_ff, rem_in;
   logic [DWidth-1:0] src;
   logic [IdxW-1:0]   bit_idx;
   logic [DWidth:0]   trial;

   assign src     = (state_ff == S_DIVN) ? n_ff : d_ff;
   assign bit_idx = IdxW'(cnt_ff - CntW'(1));
   assign trial   = {rem_ff[DWidth-1:0], src[bit_idx]} - {1'b0, g_ff};

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; n_in2 = n_ff; d_in2 = d_ff;
      k_in = k_ff; cnt_in = cnt_ff; g_in = g_ff; q_in = q_ff; rem_in = rem_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in = n_in; y_in = d_in; n_in2 = n_in; d_in2 = d_in;
               k_in = '0;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // binary gcd, one step a cycle
            if (x_ff == y_ff || x_ff == '0 || y_ff == '0) begin
               g_in   = ((x_ff == '0) ? y_ff : x_ff) << k_ff;
               cnt_in = CntW'(DWidth);
               rem_in = '0; q_in = '0;
               state_in = S_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1; y_in = y_ff >> 1; k_in = k_ff + CntW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff > y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         S_DIVN, S_DIVD: begin
            if (!trial[DWidth]) begin
               rem_in = {1'b0, trial[DWidth-1:0]};
               q_in   = {q_ff[DWidth-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DWidth-1:0], src[bit_idx]};
               q_in   = {q_ff[DWidth-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               if (state_ff == S_DIVN) begin
                  n_in2 = q_in; cnt_in = CntW'(DWidth); rem_in = '0; q_in = '0;
                  state_in = S_DIVD;
               end else begin
                  d_in2 = q_in;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in; y_ff <= y_in; n_ff <= n_in2; d_ff <= d_in2;
      k_ff <= k_in; cnt_ff <= cnt_in; g_ff <= g_in; q_ff <= q_in; rem_ff <= rem_in;
   end

   assign done  = (state_ff == S_DONE);
   assign n_out = n_ff;
   assign d_out = d_ff;

endmodule

// File: src/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// accepts requests, normalizes sign and flags zero denominators
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
   input  logic [2:0]       req_command,
   input  logic [Width-1:0] req_a_num,
   input  logic [Width-1:0] req_a_den,
   input  logic [Width-1:0] req_b_num,
   input  logic [Width-1:0] req_b_den,
   output entry_type        entry
);

   logic an, ad, bn, bd;
   logic [Width-1:0] anm, adm, bnm, bdm;

   assign an  = req_a_num[Width-1];
   assign ad  = req_a_den[Width-1];
   assign bn  = req_b_num[Width-1];
   assign bd  = req_b_den[Width-1];
   assign anm = an ? -req_a_num : req_a_num;
   assign adm = ad ? -req_a_den : req_a_den;
   assign bnm = bn ? -req_b_num : req_b_num;
   assign bdm = bd ? -req_b_den : req_b_den;

   always_comb begin
      entry.cmd   = cmd_type'(req_command);
      entry.a_neg = an ^ ad;
      entry.a_n   = anm;
      entry.a_d   = adm;
      entry.b_neg = bn ^ bd;
      entry.b_n   = bnm;
      entry.b_d   = bdm;
      if (adm == '0 || (entry.cmd != CMD_NORM && bdm == '0)) begin
         entry.st = ST_ZERO;
      end else begin
         entry.st = ST_OK;
      end
   end

endmodule

// File: src/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue
// two-entry register queue between the front and the back
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qctl_type  ctl_i,
   output logic      full,
   output logic      empty,
   input  entry_type din,
   output entry_type dout
);

   entry_type  mem_ff [QDepth];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign full  = (cnt_ff == 2'(QDepth));
   assign empty = (cnt_ff == '0);
   assign wr    = ctl_i.push && !full;
   assign rd    = ctl_i.pop && !empty;
   assign dout  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
      if (wr) mem_ff[wp_ff] <= din;
   end

endmodule

// File: src/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// carries out one request: operand reduction, cross products and, for arithmetic, result reduction
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  entry_type        q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [Width-1:0] rsp_res_num,
   output logic [Width-2:0] rsp_res_den,
   output logic             rsp_truth,
   output logic [1:0]       rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_RA, S_WA, S_RB, S_WB, S_CHK, S_M1, S_M2, S_ARITH,
      S_RR, S_WR, S_FIN, S_OUT
   } state_type;

   localparam logic [DWidth-1:0] MaxPos = DWidth'((64'd1 << (Width-1)) - 64'd1);

   state_type         state_ff;
   entry_type         e_ff;
   status_type        st_ff;
   logic              an_ff, bn_ff, rn_ff;
   logic [DWidth-1:0] a_n_ff, a_d_ff, b_n_ff, b_d_ff;
   logic [DWidth-1:0] p1_ff, p2_ff, p3_ff;
   logic [DWidth-1:0] r_n_ff, r_d_ff;
   logic              g_start;
   logic [DWidth-1:0] g_n, g_d, g_nout, g_dout;
   logic              g_done;
   logic [Width-1:0]  o_num_ff;
   logic [Width-2:0]  o_den_ff;
   logic              o_truth_ff, o_valid_ff;
   status_type        o_st_ff;
   logic              bneg;

   function automatic logic fits(input logic neg, input logic [DWidth-1:0] n,
                                 input logic [DWidth-1:0] d);
      logic [DWidth-1:0] lim;
      lim  = neg ? MaxPos + DWidth'(1) : MaxPos;
      fits = d >= DWidth'(1) && d <= MaxPos && n <= lim;
   endfunction

   rau_gcd u_gcd (
      .clock, .reset, .start(g_start), .n_in(g_n), .d_in(g_d),
      .done(g_done), .n_out(g_nout), .d_out(g_dout)
   );

   assign bneg = (e_ff.cmd == CMD_SUB) ? (b_n_ff != '0 && !bn_ff) : bn_ff;

   always_comb begin
      g_start = 1'b0;
      g_n = r_n_ff; g_d = r_d_ff;
      case (state_ff)
         S_RA: begin g_start = 1'b1; g_n = a_n_ff; g_d = a_d_ff; end
         S_RB: begin g_start = 1'b1; g_n = b_n_ff; g_d = b_d_ff; end
         S_RR: g_start = 1'b1;
         default: g_start = 1'b0;
      endcase
   end

   assign q_pop       = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty   = !o_valid_ff;
   assign rsp_res_num = o_num_ff;
   assign rsp_res_den = o_den_ff;
   assign rsp_truth   = o_truth_ff;
   assign rsp_status  = o_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         o_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!o_valid_ff || rsp_pop)) o_valid_ff <= 1'b1;
         else if (rsp_pop) o_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  e_ff   <= q_data;
                  st_ff  <= (q_data.cmd == CMD_NONE) ? ST_OK : q_data.st;
                  an_ff  <= q_data.a_neg;
                  bn_ff  <= q_data.b_neg;
                  a_n_ff <= DWidth'(q_data.a_n);
                  a_d_ff <= DWidth'(q_data.a_d);
                  b_n_ff <= DWidth'(q_data.b_n);
                  b_d_ff <= DWidth'(q_data.b_d);
                  state_ff <= (q_data.cmd == CMD_NONE || q_data.st != ST_OK) ? S_FIN
                                                                             : S_RA;
               end
            end
            S_RA: state_ff <= S_WA;
            S_WA: begin
               if (g_done) begin
                  if (a_n_ff == '0) begin
                     an_ff <= 1'b0; a_d_ff <= DWidth'(1);
                  end else begin
                     a_n_ff <= g_nout; a_d_ff <= g_dout;
                  end
                  state_ff <= (e_ff.cmd == CMD_NORM) ? S_CHK : S_RB;
               end
            end
            S_RB: state_ff <= S_WB;
            S_WB: begin
               if (g_done) begin
                  if (b_n_ff == '0) begin
                     bn_ff <= 1'b0; b_d_ff <= DWidth'(1);
                  end else begin
                     b_n_ff <= g_nout; b_d_ff <= g_dout;
                  end
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (!fits(an_ff, a_n_ff, a_d_ff) ||
                   (e_ff.cmd != CMD_NORM && !fits(bn_ff, b_n_ff, b_d_ff))) begin
                  st_ff    <= ST_WIDE;
                  state_ff <= S_FIN;
               end else if (e_ff.cmd == CMD_DIV && b_n_ff == '0) begin
                  st_ff    <= ST_ZERO;
                  state_ff <= S_FIN;
               end else if (e_ff.cmd == CMD_NORM) begin
                  rn_ff <= an_ff; r_n_ff <= a_n_ff; r_d_ff <= a_d_ff;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_M1;
               end
            end
            S_M1: begin
               // operands fit in Width bits, so each product is one 32x32
               p1_ff <= a_n_ff[Width-1:0] * ((e_ff.cmd == CMD_MUL) ? b_n_ff[Width-1:0]
                                                                  : b_d_ff[Width-1:0]);
               p2_ff <= b_n_ff[Width-1:0] * a_d_ff[Width-1:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               p3_ff <= a_d_ff[Width-1:0] * b_d_ff[Width-1:0];
               state_ff <= S_ARITH;
            end
            S_ARITH: begin
               case (e_ff.cmd)
                  CMD_ADD, CMD_SUB: begin
                     r_d_ff <= p3_ff;
                     if (an_ff == bneg) begin
                        rn_ff <= an_ff; r_n_ff <= p1_ff + p2_ff;
                     end else if (p1_ff >= p2_ff) begin
                        rn_ff <= an_ff; r_n_ff <= p1_ff - p2_ff;
                     end else begin
                        rn_ff <= bneg; r_n_ff <= p2_ff - p1_ff;
                     end
                     state_ff <= S_RR;
                  end
                  CMD_MUL: begin
                     rn_ff <= an_ff ^ bn_ff; r_n_ff <= p1_ff; r_d_ff <= p3_ff;
                     state_ff <= S_RR;
                  end
                  CMD_DIV: begin
                     rn_ff <= an_ff ^ bn_ff; r_n_ff <= p1_ff; r_d_ff <= p2_ff;
                     state_ff <= S_RR;
                  end
                  CMD_LT: state_ff <= S_FIN;
                  CMD_EQ: state_ff <= S_FIN;
                  default: state_ff <= S_FIN;
               endcase
            end
            S_RR: state_ff <= S_WR;
            S_WR: begin
               if (g_done) begin
                  if (r_n_ff == '0) begin
                     rn_ff <= 1'b0; r_d_ff <= DWidth'(1);
                  end else begin
                     r_n_ff <= g_nout; r_d_ff <= g_dout;
                  end
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!o_valid_ff || rsp_pop) begin
                  if (st_ff != ST_OK || e_ff.cmd == CMD_NONE) begin
                     o_num_ff   <= '0;
                     o_den_ff   <= '0;
                     o_truth_ff <= 1'b0;
                     o_st_ff    <= st_ff;
                  end else if (e_ff.cmd == CMD_LT) begin
                     o_num_ff   <= '0;
                     o_den_ff   <= '0;
                     o_truth_ff <= (an_ff != bn_ff) ? an_ff :
                                   an_ff ? (p1_ff > p2_ff) : (p1_ff < p2_ff);
                     o_st_ff    <= ST_OK;
                  end else if (e_ff.cmd == CMD_EQ) begin
                     o_num_ff   <= '0;
                     o_den_ff   <= '0;
                     o_truth_ff <= an_ff == bn_ff && a_n_ff == b_n_ff &&
                                   a_d_ff == b_d_ff;
                     o_st_ff    <= ST_OK;
                  end else if (fits(rn_ff, r_n_ff, r_d_ff)) begin
                     o_num_ff   <= rn_ff ? -r_n_ff[Width-1:0] : r_n_ff[Width-1:0];
                     o_den_ff   <= r_d_ff[Width-2:0];
                     o_truth_ff <= 1'b0;
                     o_st_ff    <= ST_OK;
                  end else begin
                     o_num_ff   <= '0;
                     o_den_ff   <= '0;
                     o_truth_ff <= 1'b0;
                     o_st_ff    <= ST_WIDE;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
